FILE: sv/dhs_pkg.sv
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared types and character codes for the decimal or hex string parser.
// ----------------------------------------------------------------------------
package dhs_pkg;

  localparam int unsigned OUT_BITS = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic                ok;
    logic [OUT_BITS-1:0] value;
  } result_t;

endpackage

FILE: sv/dhs_char_if.sv
// ----------------------------------------------------------------------------
// dhs_char_if
// Channel carrying one ASCII byte per item.
// ----------------------------------------------------------------------------
interface dhs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

FILE: sv/dhs_result_if.sv
// ----------------------------------------------------------------------------
// dhs_result_if
// Channel carrying one parse result per item.
// ----------------------------------------------------------------------------
interface dhs_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] value;

  modport source (output valid, output ok, output value, input ready);
  modport sink (input valid, input ok, input value, output ready);
endinterface

FILE: sv/dhs_in_stage.sv
// ----------------------------------------------------------------------------
// dhs_in_stage
// Input register that holds one byte until the parser consumes it.
// ----------------------------------------------------------------------------
module dhs_in_stage (
  input  logic         clk,
  input  logic         rst,
  dhs_char_if.sink     chars,
  input  logic         take,
  output logic         in_valid,
  output logic [7:0]   in_char
);

  assign chars.ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.char_code;
    end
  end

endmodule

FILE: sv/dhs_core.sv
// ----------------------------------------------------------------------------
// dhs_core
// Parser state and the update that consumes a registered byte.
// ----------------------------------------------------------------------------
module dhs_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       in_char,
  input  logic             out_free,
  output logic             take,
  output logic             emit,
  output dhs_pkg::result_t res
);
  import dhs_pkg::*;

  localparam int unsigned VIS_BITS = (VALUE_BITS < OUT_BITS) ? VALUE_BITS : OUT_BITS;

  phase_t                phase;
  phase_t                phase_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  hex_mode;
  logic                  hex_mode_next;

  logic                  is_dec;
  logic                  is_upper;
  logic                  is_lower;
  logic                  is_digit;
  logic                  is_space;
  logic                  is_x;
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] acc_hex;
  logic [VALUE_BITS-1:0] acc_dec;
  logic [OUT_BITS-1:0]   acc_out;

  assign take = in_valid && out_free;

  assign is_dec   = (in_char >= CH_0) && (in_char <= CH_9);
  assign is_upper = hex_mode && (in_char >= CH_UA) && (in_char <= CH_UF);
  assign is_lower = hex_mode && (in_char >= CH_LA) && (in_char <= CH_LF_HEX);
  assign is_digit = is_dec || is_upper || is_lower;
  assign is_space = (in_char == CH_SPACE) || (in_char == CH_TAB) || (in_char == CH_LF);
  assign is_x     = (in_char == CH_LX) || (in_char == CH_UX);

  always_comb begin
    priority if (is_dec) begin
      digit = 4'(in_char - CH_0);
    end else if (is_upper) begin
      digit = 4'(in_char - CH_UA + 8'd10);
    end else if (is_lower) begin
      digit = 4'(in_char - CH_LA + 8'd10);
    end else begin
      digit = 4'd0;
    end
  end

  assign acc_hex = (acc << 4) + VALUE_BITS'(digit);
  assign acc_dec = (acc << 3) + (acc << 1) + VALUE_BITS'(digit);
  assign acc_out = OUT_BITS'(acc[VIS_BITS-1:0]);

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    hex_mode_next = hex_mode;
    emit          = 1'b0;
    res.ok        = 1'b1;
    res.value     = acc_out;
    if (in_char == CH_NUL) begin
      emit          = (phase != PH_SKIP);
      phase_next    = PH_START;
      acc_next      = '0;
      hex_mode_next = 1'b0;
    end else if (phase == PH_SKIP) begin
      emit = 1'b0;
    end else if ((phase == PH_ZERO) && is_x) begin
      hex_mode_next = 1'b1;
      acc_next      = '0;
      phase_next    = PH_DIGITS;
    end else if (is_space) begin
      emit       = 1'b1;
      phase_next = PH_SKIP;
    end else if (!is_digit) begin
      emit       = 1'b1;
      res.ok     = 1'b0;
      res.value  = '0;
      acc_next   = '0;
      phase_next = PH_SKIP;
    end else begin
      acc_next = hex_mode ? acc_hex : acc_dec;
      if ((phase == PH_START) && (in_char == CH_0)) begin
        phase_next = PH_ZERO;
      end else begin
        phase_next = PH_DIGITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      acc      <= '0;
      hex_mode <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      acc      <= acc_next;
      hex_mode <= hex_mode_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_nul_restarts: assert property (@(posedge clk) disable iff (rst)
    take && (in_char == CH_NUL) |=> (phase == PH_START) && (acc == '0) && !hex_mode)
    else $error("A string end did not restart the parser.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    take && emit && !res.ok |-> (res.value == '0))
    else $error("A failed parse carried a nonzero value.");

  a_hex_phase: assert property (@(posedge clk) disable iff (rst)
    hex_mode |-> (phase == PH_DIGITS) || (phase == PH_SKIP))
    else $error("Hex mode is set outside the digit or skip phases.");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    take && (phase == PH_SKIP) && (in_char != CH_NUL) |-> !emit)
    else $error("A skipped byte produced a result.");
`endif

endmodule

FILE: sv/dhs_out_stage.sv
// ----------------------------------------------------------------------------
// dhs_out_stage
// Result register that holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module dhs_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             emit,
  input  dhs_pkg::result_t res,
  output logic             out_free,
  dhs_result_if.source     results
);
  import dhs_pkg::*;

  logic    out_valid;
  result_t held;
  logic    load;

  assign out_free = !out_valid || results.ready;
  assign load     = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.ok    = held.ok;
  assign results.value = held.value;

endmodule

FILE: sv/decimal_hex_string_to_unsigned.sv
// ----------------------------------------------------------------------------
// decimal_hex_string_to_unsigned
// Streaming parser of NUL-terminated decimal or 0x-prefixed hex strings.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload               Per item
// chars     in   char_code[7:0]        one string byte
// results   out  ok, value[31:0]       one parse result
//
// Each byte is registered, then consumed by the shift-add update of the
// accumulator, so one byte is taken in every cycle unless the result stalls.
// A result passes through the byte register, then the result register.
// Reset clears the parser to the start of a string and empties both registers.
// A stalled result holds the byte stage, even for a byte that gives no result.
// ----------------------------------------------------------------------------
module decimal_hex_string_to_unsigned #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic          clk,
  input logic          rst,
  dhs_char_if.sink     chars,
  dhs_result_if.source results
);
  import dhs_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       take;
  logic       emit;
  logic       out_free;
  result_t    res;

  dhs_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .take     (take),
    .in_valid (in_valid),
    .in_char  (in_char)
  );

  dhs_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_char  (in_char),
    .out_free (out_free),
    .take     (take),
    .emit     (emit),
    .res      (res)
  );

  dhs_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .emit     (emit),
    .res      (res),
    .out_free (out_free),
    .results  (results)
  );

endmodule
